### hw/rtl/wrv_pkg.sv
// Shared types, widths and constants for the window regression velocity block.
package wrv_pkg;

    // Default number of samples the window store can hold.
    localparam int DEPTH_DEF = 32;

    // Field and register widths.
    localparam int TIME_W   = 48;
    localparam int POS_W    = 32;
    localparam int STAMP_W  = 64;
    localparam int CFG_W    = 31;
    localparam int IDX_W    = 3;
    localparam int WL_W     = 6;
    localparam int WEIGHT_W = 17;
    localparam int SPAN_W   = 24;
    localparam int GAP_W    = 24;
    localparam int SPEED_W  = 31;
    localparam int STATUS_W = 3;
    localparam int QUO_W    = 32;
    localparam int SQ_W     = 64;

    // Unity smoothing weight in Q1.16 and the microseconds-per-second scale.
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_HALF = 17'd32768;
    localparam int                  SCALE_W     = 20;
    localparam logic [SCALE_W-1:0]  SCALE_US    = 20'd1000000;

    // Register reset values.
    localparam logic [WL_W-1:0]     WL_RST       = 6'd20;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = 17'd22938;
    localparam logic [SPAN_W-1:0]   MIN_SPAN_RST = 24'd40000;
    localparam logic [GAP_W-1:0]    MAX_GAP_RST  = 24'd500000;
    localparam logic [SPEED_W-1:0]  SPEED_RST    = 31'd524288;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 3'd0,
        CFG_SMOOTHING     = 3'd1,
        CFG_MIN_SPAN      = 3'd2,
        CFG_MAX_GAP       = 3'd3,
        CFG_SPEED_LIMIT   = 3'd4
    } t_cfg_idx;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_WARMING    = 3'd0,
        ST_UPDATED    = 3'd1,
        ST_BAD_POSE   = 3'd2,
        ST_GAP_RESET  = 3'd3,
        ST_DEGENERATE = 3'd4,
        ST_REJECTED   = 3'd5
    } t_status;

    // Step strobes from the sequencer to the axis lanes.
    typedef struct packed {
        logic clr;
        logic step;
        logic mul_init;
        logic mul_en;
        logic mbit;
        logic diff;
        logic sc_en;
        logic kbit;
        logic dchk;
        logic div_en;
        logic sat;
        logic sq;
        logic ld_first;
        logic ema1;
        logic ema2;
    } t_lane_ctl;

endpackage

### hw/rtl/wrv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wrv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/wrv_lane.sv
// One axis lane: position sums, numerator, scaling, serial division, clamp and smoothing.
module wrv_lane #(
    parameter int TW   = 29,
    parameter int CW   = 6,
    parameter int DW   = 70
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wrv_pkg::t_lane_ctl            i_ctl,
    input  logic [TW-1:0]                 i_t,
    input  logic signed [wrv_pkg::POS_W-1:0] i_p,
    input  logic [CW-1:0]                 i_n,
    input  logic [DW-1:0]                 i_den,
    input  logic [wrv_pkg::WEIGHT_W-1:0]  i_weight,
    output logic [wrv_pkg::SQ_W-1:0]      o_sq,
    output logic signed [wrv_pkg::POS_W-1:0] o_vel
);
    import wrv_pkg::*;

    localparam int SP_W  = POS_W + CW;
    localparam int PR_W  = TW + POS_W + 1;
    localparam int NW    = PR_W + 2 * CW + 2;
    localparam int MW    = NW + SCALE_W;
    localparam int CMP_W = (MW > DW + QUO_W) ? MW : DW + QUO_W;
    localparam int EP_W  = WEIGHT_W + 1 + POS_W;

    logic signed [PR_W-1:0]  r_prod;
    logic signed [POS_W-1:0] r_p;
    logic                    r_v2;
    logic signed [SP_W-1:0]  r_sp;
    logic signed [NW-1:0]    r_stp;
    logic signed [NW-1:0]    r_mc;
    logic signed [NW-1:0]    r_acc;
    logic                    r_neg;
    logic [MW-1:0]           r_msh;
    logic [MW-1:0]           r_sc;
    logic                    r_ovf;
    logic [DW-1:0]           r_rem;
    logic [QUO_W-1:0]        r_low;
    logic [QUO_W-1:0]        r_q;
    logic signed [POS_W-1:0] r_cand;
    logic [SQ_W-1:0]         r_sq;
    logic signed [EP_W-1:0]  r_pa;
    logic signed [EP_W-1:0]  r_pb;
    logic signed [POS_W-1:0] r_filt;

    logic signed [PR_W-1:0]  prod_c;
    logic signed [NW-1:0]    num_c;
    logic [NW-1:0]           mag_c;
    logic [CMP_W-1:0]        den_sh_c;
    logic [DW:0]             rr_c;
    logic [DW:0]             den_ext_c;
    logic signed [EP_W:0]    ema_c;
    logic signed [2*POS_W-1:0] sq_c;

    // Combinational helpers for the current step.
    assign prod_c    = $signed({1'b0, i_t}) * i_p;
    assign num_c     = r_stp * $signed({1'b0, i_n}) - r_acc;
    assign mag_c     = num_c[NW-1] ? (NW'(0) - num_c) : num_c;
    assign den_sh_c  = CMP_W'({i_den, {QUO_W{1'b0}}});
    assign rr_c      = {r_rem, r_low[QUO_W-1]};
    assign den_ext_c = {1'b0, i_den};
    assign ema_c     = (EP_W + 1)'(r_pa) + (EP_W + 1)'(r_pb)
                     + $signed({{(EP_W + 1 - WEIGHT_W){1'b0}}, WEIGHT_HALF});
    assign sq_c      = r_cand * r_cand;

    // Datapath registers, one group per sequencer step.
    always_ff @(posedge i_clk) begin
        // Window walk: product stage then accumulation.
        r_v2   <= i_ctl.step;
        r_prod <= prod_c;
        r_p    <= i_p;
        if (i_ctl.clr) begin
            r_sp  <= '0;
            r_stp <= '0;
        end else if (r_v2) begin
            r_sp  <= r_sp + SP_W'(r_p);
            r_stp <= r_stp + NW'(r_prod);
        end
        // Serial product of the time sum with the position sum.
        if (i_ctl.mul_init) begin
            r_mc  <= NW'(r_sp);
            r_acc <= '0;
        end else if (i_ctl.mul_en) begin
            r_mc <= r_mc <<< 1;
            if (i_ctl.mbit) begin
                r_acc <= r_acc + r_mc;
            end
        end
        // Numerator magnitude, then serial scaling to microseconds.
        if (i_ctl.diff) begin
            r_neg <= num_c[NW-1];
            r_msh <= MW'(mag_c);
            r_sc  <= '0;
        end else if (i_ctl.sc_en) begin
            r_msh <= r_msh << 1;
            if (i_ctl.kbit) begin
                r_sc <= r_sc + r_msh;
            end
        end
        // Overflow check and restoring division, one quotient bit a cycle.
        if (i_ctl.dchk) begin
            r_ovf <= CMP_W'(r_sc) >= den_sh_c;
            r_rem <= DW'(r_sc >> QUO_W);
            r_low <= r_sc[QUO_W-1:0];
            r_q   <= '0;
        end else if (i_ctl.div_en) begin
            r_low <= r_low << 1;
            if (rr_c >= den_ext_c) begin
                r_rem <= DW'(rr_c - den_ext_c);
                r_q   <= {r_q[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= DW'(rr_c);
                r_q   <= {r_q[QUO_W-2:0], 1'b0};
            end
        end
        // Saturate to 32 bits and square for the speed check.
        if (i_ctl.sat) begin
            if (r_neg) begin
                if (r_ovf || r_q > {1'b1, {(QUO_W-1){1'b0}}}) begin
                    r_cand <= $signed({1'b1, {(POS_W-1){1'b0}}});
                end else begin
                    r_cand <= $signed(POS_W'(0) - r_q);
                end
            end else begin
                if (r_ovf || r_q[QUO_W-1]) begin
                    r_cand <= $signed({1'b0, {(POS_W-1){1'b1}}});
                end else begin
                    r_cand <= $signed(r_q);
                end
            end
        end
        if (i_ctl.sq) begin
            r_sq <= SQ_W'(sq_c);
        end
        // Smoothing products.
        if (i_ctl.ema1) begin
            r_pa <= $signed({1'b0, i_weight}) * r_cand;
            r_pb <= $signed({1'b0, WEIGHT_ONE - i_weight}) * r_filt;
        end
    end

    // Held filtered velocity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
        end else if (i_ctl.ld_first) begin
            r_filt <= r_cand;
        end else if (i_ctl.ema2) begin
            r_filt <= ema_c[POS_W+15:16];
        end
    end

    assign o_sq  = r_sq;
    assign o_vel = r_filt;

endmodule

### hw/rtl/window_regression_velocity.sv
// Top level of the sliding-window least-squares velocity estimator with smoothing.
// Each accepted word carries a time, a position and a sender stamp and yields one result
// word. A word with an invalid pose, or one that leaves a single sample in the window,
// goes straight to the done state; one whose window spans too short a time goes there
// after the base and span states. A rejected or first candidate skips the smoothing
// states. For a full estimate the walk reads one sample a cycle from the sample RAM,
// then a bit-serial product of the time sum (35 steps at the default depth), a 20-step
// scale by one million and a 32-step division set the figure; the three axes run in
// parallel lanes. A new input word is taken once the previous one is finished, even
// while its result still waits at the output register. There is no clearing pass after
// reset.
module window_regression_velocity #(
    parameter int WINDOW_DEPTH = wrv_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wrv_pkg::IDX_W-1:0]           i_cfg_idx,
    input  logic [wrv_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [wrv_pkg::TIME_W-1:0]          i_arrival_time_us,
    input  logic signed [wrv_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [wrv_pkg::POS_W-1:0]    i_pos_y,
    input  logic signed [wrv_pkg::POS_W-1:0]    i_pos_z,
    input  logic                                i_pose_valid,
    input  logic signed [wrv_pkg::STAMP_W-1:0]  i_source_stamp_ns,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [wrv_pkg::POS_W-1:0]    o_vel_x,
    output logic signed [wrv_pkg::POS_W-1:0]    o_vel_y,
    output logic signed [wrv_pkg::POS_W-1:0]    o_vel_z,
    output logic [wrv_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_stamp_rolled_back
);
    import wrv_pkg::*;

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int TW    = GAP_W + AW;
    localparam int ST_W  = TW + CW;
    localparam int STT_W = 2 * TW + CW;
    localparam int DW    = 2 * TW + 2 * CW;
    localparam int RW    = TIME_W + 3 * POS_W;
    localparam int MAXC  = (ST_W > QUO_W) ? ST_W : QUO_W;
    localparam int CNT_W = $clog2(MAXC + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_BASE, S_SPAN, S_WALK, S_MUL, S_DIFF, S_SCALE, S_DCHK,
        S_DIV, S_SAT, S_SQ, S_LIM, S_EMA1, S_EMA2, S_DONE
    } t_state;

    t_state                 r_state;
    logic [WL_W-1:0]        r_wl;
    logic [WEIGHT_W-1:0]    r_weight;
    logic [SPAN_W-1:0]      r_min_span;
    logic [GAP_W-1:0]       r_max_gap;
    logic [SPEED_W-1:0]     r_speed;
    logic [AW-1:0]          r_head;
    logic [CW-1:0]          r_count;
    logic [TIME_W-1:0]      r_newest;
    logic [TIME_W-1:0]      r_now;
    logic [TIME_W-1:0]      r_base;
    logic [AW-1:0]          r_oldest;
    logic [AW-1:0]          r_addr;
    logic [CW-1:0]          r_iss;
    logic                   r_v1;
    logic                   r_v2;
    logic [TW-1:0]          r_t2;
    logic [2*TW-1:0]        r_tt;
    logic [ST_W-1:0]        r_st;
    logic [STT_W-1:0]       r_stt;
    logic [ST_W-1:0]        r_mq;
    logic [DW-1:0]          r_mcand;
    logic [DW-1:0]          r_sq;
    logic [DW-1:0]          r_den;
    logic [SCALE_W-1:0]     r_kbits;
    logic [CNT_W-1:0]       r_cnt;
    logic [2*SPEED_W-1:0]   r_lim;
    t_status                r_status;
    logic                   r_roll;
    logic                   r_have_est;
    logic                   r_have_stamp;
    logic [STAMP_W-1:0]     r_last_stamp;
    logic                   r_o_valid;
    logic signed [POS_W-1:0] r_o_vx;
    logic signed [POS_W-1:0] r_o_vy;
    logic signed [POS_W-1:0] r_o_vz;
    t_status                r_o_status;
    logic                   r_o_roll;

    logic                   in_acc;
    logic                   out_free;
    logic                   gap_c;
    logic [CW-1:0]          wl_eff_c;
    logic [CW:0]            cnt_inc_c;
    logic [CW-1:0]          n_count;
    logic [AW-1:0]          n_head;
    logic [CW:0]            old_sum_c;
    logic [AW-1:0]          oldest_c;
    logic [AW-1:0]          raddr_c;
    logic [RW-1:0]          rdata;
    logic [TIME_W-1:0]      rd_time_c;
    logic [TW-1:0]          t_c;
    logic [STT_W+CW-1:0]    nstt_c;
    logic [SQ_W-1:0]        sq_x, sq_y, sq_z;
    logic [SQ_W-1:0]        sq_sum_c;
    logic [WEIGHT_W-1:0]    weight_c;
    logic                   walk_done_c;
    t_lane_ctl              ctl;
    logic signed [POS_W-1:0] o_vel_x_c;
    logic signed [POS_W-1:0] o_vel_y_c;
    logic signed [POS_W-1:0] o_vel_z_c;

    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_o_valid || !i_stall;

    // Window length clamped to between two and the store depth.
    always_comb begin
        if (r_wl < WL_W'(2)) begin
            wl_eff_c = CW'(2);
        end else if (int'(r_wl) > WINDOW_DEPTH) begin
            wl_eff_c = CW'(WINDOW_DEPTH);
        end else begin
            wl_eff_c = CW'(r_wl);
        end
    end

    // Gap check and window bookkeeping for the incoming sample.
    assign gap_c = (r_count != '0) && ((i_arrival_time_us <= r_newest) ||
                   ((i_arrival_time_us - r_newest) > TIME_W'(r_max_gap)));
    assign cnt_inc_c = (gap_c ? (CW + 1)'(0) : (CW + 1)'(r_count)) + (CW + 1)'(1);
    assign n_count   = (cnt_inc_c > (CW + 1)'(wl_eff_c)) ? wl_eff_c : CW'(cnt_inc_c);
    assign n_head    = (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + AW'(1);

    // Oldest sample slot from head and count.
    assign old_sum_c = (CW + 1)'(r_head) + (CW + 1)'(WINDOW_DEPTH) - (CW + 1)'(r_count);
    assign oldest_c  = (old_sum_c >= (CW + 1)'(WINDOW_DEPTH))
                     ? AW'(old_sum_c - (CW + 1)'(WINDOW_DEPTH)) : AW'(old_sum_c);

    assign raddr_c   = (r_state == S_BASE) ? oldest_c : r_addr;
    assign rd_time_c = rdata[RW-1:3*POS_W];
    assign t_c       = TW'(rd_time_c - r_base);
    assign nstt_c    = r_stt * r_count;
    assign sq_sum_c  = sq_x + sq_y + sq_z;
    assign weight_c  = (r_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_weight;
    assign walk_done_c = (r_iss == r_count) && !r_v1 && !r_v2;

    // Sample store: time over z, y, x.
    wrv_ram #(
        .WIDTH (RW),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && i_pose_valid),
        .i_waddr (r_head),
        .i_wdata ({i_arrival_time_us, i_pos_z, i_pos_y, i_pos_x}),
        .i_raddr (raddr_c),
        .o_rdata (rdata)
    );

    // Lane strobes decoded from the sequencer state.
    always_comb begin
        ctl          = '0;
        ctl.clr      = (r_state == S_SPAN);
        ctl.step     = r_v1;
        ctl.mul_init = (r_state == S_WALK) && walk_done_c;
        ctl.mul_en   = (r_state == S_MUL);
        ctl.mbit     = r_mq[0];
        ctl.diff     = (r_state == S_DIFF);
        ctl.sc_en    = (r_state == S_SCALE);
        ctl.kbit     = r_kbits[0];
        ctl.dchk     = (r_state == S_DCHK) && (r_den != '0);
        ctl.div_en   = (r_state == S_DIV);
        ctl.sat      = (r_state == S_SAT);
        ctl.sq       = (r_state == S_SQ);
        ctl.ld_first = (r_state == S_LIM) && (sq_sum_c <= SQ_W'(r_lim)) && !r_have_est;
        ctl.ema1     = (r_state == S_LIM) && (sq_sum_c <= SQ_W'(r_lim)) && r_have_est;
        ctl.ema2     = (r_state == S_EMA2);
    end

    wrv_lane #(.TW(TW), .CW(CW), .DW(DW)) u_lane_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (ctl), .i_t (t_c),
        .i_p ($signed(rdata[POS_W-1:0])), .i_n (r_count), .i_den (r_den),
        .i_weight (weight_c), .o_sq (sq_x), .o_vel (o_vel_x_c)
    );
    wrv_lane #(.TW(TW), .CW(CW), .DW(DW)) u_lane_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (ctl), .i_t (t_c),
        .i_p ($signed(rdata[2*POS_W-1:POS_W])), .i_n (r_count), .i_den (r_den),
        .i_weight (weight_c), .o_sq (sq_y), .o_vel (o_vel_y_c)
    );
    wrv_lane #(.TW(TW), .CW(CW), .DW(DW)) u_lane_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (ctl), .i_t (t_c),
        .i_p ($signed(rdata[3*POS_W-1:2*POS_W])), .i_n (r_count), .i_den (r_den),
        .i_weight (weight_c), .o_sq (sq_z), .o_vel (o_vel_z_c)
    );

    // Sequencer, shared time sums and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wl         <= WL_RST;
            r_weight     <= WEIGHT_RST;
            r_min_span   <= MIN_SPAN_RST;
            r_max_gap    <= MAX_GAP_RST;
            r_speed      <= SPEED_RST;
            r_head       <= '0;
            r_count      <= '0;
            r_have_est   <= 1'b0;
            r_have_stamp <= 1'b0;
            r_last_stamp <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WINDOW_LENGTH: r_wl       <= i_cfg_data[WL_W-1:0];
                    CFG_SMOOTHING:     r_weight   <= i_cfg_data[WEIGHT_W-1:0];
                    CFG_MIN_SPAN:      r_min_span <= i_cfg_data[SPAN_W-1:0];
                    CFG_MAX_GAP:       r_max_gap  <= i_cfg_data[GAP_W-1:0];
                    CFG_SPEED_LIMIT:   r_speed    <= i_cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end

            // Result register hands off; a word finishing this cycle reloads it below.
            if (r_o_valid && !i_stall && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end

            // Walk pipeline: read issue, then time offset and square.
            r_v1 <= (r_state == S_WALK) && (r_iss != r_count);
            r_v2 <= r_v1;
            r_t2 <= t_c;
            r_tt <= t_c * t_c;
            if (r_v2) begin
                r_st  <= r_st + ST_W'(r_t2);
                r_stt <= r_stt + STT_W'(r_tt);
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_roll       <= r_have_stamp &&
                                        (i_source_stamp_ns < $signed(r_last_stamp));
                        r_last_stamp <= i_source_stamp_ns;
                        r_have_stamp <= 1'b1;
                        if (!i_pose_valid) begin
                            r_status <= ST_BAD_POSE;
                            r_state  <= S_DONE;
                        end else begin
                            r_head   <= n_head;
                            r_count  <= n_count;
                            r_newest <= i_arrival_time_us;
                            r_now    <= i_arrival_time_us;
                            r_status <= gap_c ? ST_GAP_RESET : ST_WARMING;
                            r_state  <= (n_count < CW'(2)) ? S_DONE : S_BASE;
                        end
                    end
                end
                S_BASE: begin
                    r_oldest <= oldest_c;
                    r_state  <= S_SPAN;
                end
                S_SPAN: begin
                    r_base <= rd_time_c;
                    r_st   <= '0;
                    r_stt  <= '0;
                    r_addr <= r_oldest;
                    r_iss  <= '0;
                    if ((r_now - rd_time_c) < TIME_W'(r_min_span)) begin
                        r_status <= ST_WARMING;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_iss != r_count) begin
                        r_iss  <= r_iss + CW'(1);
                        r_addr <= (r_addr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_addr + AW'(1);
                    end
                    if (walk_done_c) begin
                        r_mq    <= r_st;
                        r_mcand <= DW'(r_st);
                        r_sq    <= '0;
                        r_cnt   <= CNT_W'(ST_W);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_mq    <= r_mq >> 1;
                    r_mcand <= r_mcand << 1;
                    if (r_mq[0]) begin
                        r_sq <= r_sq + r_mcand;
                    end
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_den   <= DW'(nstt_c) - r_sq;
                    r_kbits <= SCALE_US;
                    r_cnt   <= CNT_W'(SCALE_W);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_kbits <= r_kbits >> 1;
                    r_cnt   <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_DCHK;
                    end
                end
                S_DCHK: begin
                    r_cnt <= CNT_W'(QUO_W);
                    if (r_den == '0) begin
                        r_status <= ST_DEGENERATE;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    r_lim   <= r_speed * r_speed;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    if (sq_sum_c > SQ_W'(r_lim)) begin
                        r_status <= ST_REJECTED;
                        r_state  <= S_DONE;
                    end else if (!r_have_est) begin
                        r_have_est <= 1'b1;
                        r_status   <= ST_UPDATED;
                        r_state    <= S_DONE;
                    end else begin
                        r_state <= S_EMA1;
                    end
                end
                S_EMA1: begin
                    r_state <= S_EMA2;
                end
                S_EMA2: begin
                    r_status <= ST_UPDATED;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_vx     <= o_vel_x_c;
                        r_o_vy     <= o_vel_y_c;
                        r_o_vz     <= o_vel_z_c;
                        r_o_status <= r_status;
                        r_o_roll   <= r_roll;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid             = r_o_valid;
    assign o_vel_x             = r_o_vx;
    assign o_vel_y             = r_o_vy;
    assign o_vel_z             = r_o_vz;
    assign o_status            = r_o_status;
    assign o_stamp_rolled_back = r_o_roll;

endmodule
